@@ design/kgsr_pkg.sv @@
// Shared types and constants for the k-group stream reverser.
package kgsr_pkg;

  localparam int CFG_W = 5;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic run_last;
    logic list_done;
  } kgsr_cmd_t;

endpackage

@@ design/k_group_stream_reverser.sv @@
// Top level of the k-group stream reverser.
//
//   channel  direction  payload
//   s_*      in         tdata: item_value; tlast: list_last
//   m_*      out        tdata: out_value; tuser: run_last; tlast: list_done
//   cfg_*    in         data: group_size
//
// An item that only adds to a group is written into the group buffer. An item that
// completes a group or ends a list also starts a drain that emits the group, and the
// single read port of the group buffer is walked one entry per cycle.
// Input is not taken while a group drains; m_tready low pauses the drain.
// Synchronous reset clears the fill count, the drain state and the output
// valid; the group size resets to one.
module k_group_stream_reverser #(
  parameter int MAX_GROUP = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // item_value
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // out_value
  output logic                                  m_tlast,
  output logic [0:0]                            m_tuser,  // run_last
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kgsr_pkg::CFG_W-1:0]            cfg_data
);
  import kgsr_pkg::*;

  localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int AW  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW  = $clog2(MAX_GROUP + 1);

  kgsr_cmd_t      cmd;
  logic           out_stall;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;

  kgsr_ctrl #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  kgsr_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_GROUP  (MAX_GROUP),
    .AW         (AW),
    .TDW        (TDW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .wr_data   (s_tdata[DATA_WIDTH-1:0]),
    .out_stall (out_stall),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  a_list_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("list_done without run_last");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.rd_en))
    else $error("buffer write and read issued together");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("list end did not start a drain");

endmodule

@@ design/kgsr_ctrl.sv @@
// Controller: group fill tracking, drain sequencing and the group size register.
module kgsr_ctrl #(
  parameter int MAX_GROUP = 16,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [kgsr_pkg::CFG_W-1:0] cfg_data,
  input  logic                  out_stall,
  output kgsr_pkg::kgsr_cmd_t   cmd,
  output logic [AW-1:0]         wr_addr,
  output logic [AW-1:0]         rd_addr
);
  import kgsr_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] group_size;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    idx;
  logic             rev;
  logic             lst;

  logic [CW-1:0]    keff;
  logic [CW-1:0]    fill_inc;
  logic [CW-1:0]    rev_idx;
  logic             accept;
  logic             full;
  logic             final_rd;

  always_comb begin
    if (group_size == '0) begin
      keff = CW'(1);
    end else if (int'(group_size) > MAX_GROUP) begin
      keff = CW'(MAX_GROUP);
    end else begin
      keff = CW'(group_size);
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign fill_inc  = fill + CW'(1);
  assign full      = (fill_inc >= keff);
  assign rev_idx   = cnt - CW'(1) - idx;
  assign final_rd  = (idx == cnt - CW'(1));

  assign wr_addr = fill[AW-1:0];
  assign rd_addr = rev ? rev_idx[AW-1:0] : idx[AW-1:0];

  assign cmd.wr_en     = accept;
  assign cmd.rd_en     = (state == ST_DRAIN) && !out_stall;
  assign cmd.run_last  = final_rd;
  assign cmd.list_done = final_rd && lst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      group_size <= CFG_W'(1);
      fill       <= '0;
      cnt        <= '0;
      idx        <= '0;
      rev        <= 1'b0;
      lst        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        group_size <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (full || s_tlast) begin
              state <= ST_DRAIN;
              cnt   <= fill_inc;
              idx   <= '0;
              rev   <= full;
              lst   <= s_tlast;
              fill  <= '0;
            end else begin
              fill <= fill_inc;
            end
          end
        end
        ST_DRAIN: begin
          if (cmd.rd_en) begin
            idx <= idx + CW'(1);
            if (final_rd) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/kgsr_datapath.sv @@
// Datapath: group buffer memory and the registered output stage.
module kgsr_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int MAX_GROUP = 16,
  parameter int AW = 4,
  parameter int TDW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kgsr_pkg::kgsr_cmd_t   cmd,
  input  logic [AW-1:0]         wr_addr,
  input  logic [AW-1:0]         rd_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic                  out_stall,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDW-1:0]        m_tdata,
  output logic                  m_tlast,
  output logic [0:0]            m_tuser
);
  import kgsr_pkg::*;

  logic [DATA_WIDTH-1:0] mem [MAX_GROUP];
  logic [DATA_WIDTH-1:0] rdata;
  logic                  ovalid;
  logic                  run_last;
  logic                  list_done;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata     <= mem[rd_addr];
      run_last  <= cmd.run_last;
      list_done <= cmd.list_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.rd_en) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  assign out_stall  = ovalid && !m_tready;
  assign m_tvalid   = ovalid;
  assign m_tdata    = TDW'(rdata);
  assign m_tlast    = list_done;
  assign m_tuser[0] = run_last;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the k-group stream reverser: directed rows, then random lists.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = 32;
  localparam int MAX_GRP = 16;
  localparam int SETTLE = 4;
  localparam int RANDOM_ITEMS = 406;
  localparam int NUM_ROWS = 29;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              run_last;
    logic              list_done;
  } result_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              typed;
    result_t           want;
  } row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [DATA_W-1:0]           s_tdata = '0;  // item_value
  logic                        s_tlast = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [DATA_W-1:0]           m_tdata;  // out_value
  logic                        m_tlast;
  logic [0:0]                  m_tuser;  // run_last
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [kgsr_pkg::CFG_W-1:0]  cfg_data = '0;

  logic    item_typed = 1'b0;
  result_t item_want = '0;
  logic    steady = 1'b0;

  logic [DATA_W-1:0] grp_store [MAX_GRP];
  int                grp_fill = 0;
  logic [kgsr_pkg::CFG_W-1:0] grp_size_reg = kgsr_pkg::CFG_W'(1);
  result_t           reorder_out[$];
  result_t           awaited_values[$];

  int errors = 0;
  int items_taken = 0;
  int values_checked = 0;
  int size_writes = 0;

  row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ITEM, 32'h7fff_ffff, 1'b0, 1'b1, '{32'h7fff_ffff, 1'b1, 1'b0}},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b1}},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{ROW_ITEM, 32'hffff_ffff, 1'b1, 1'b1, '{32'hffff_ffff, 1'b1, 1'b1}},
    '{ROW_CFG,  32'd3,         1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0011, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0022, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0033, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0044, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0055, 1'b1, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0066, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0077, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0088, 1'b1, 1'b0, '0},
    '{ROW_CFG,  32'd16,        1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'ha1a1_a1a1, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'ha2a2_a2a2, 1'b0, 1'b0, '0},
    '{ROW_CFG,  32'd1,         1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'ha3a3_a3a3, 1'b0, 1'b0, '0},
    '{ROW_CFG,  32'd0,         1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'h5a5a_5a5a, 1'b1, 1'b1, '{32'h5a5a_5a5a, 1'b1, 1'b1}},
    '{ROW_CFG,  32'd31,        1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb1b1_b1b1, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb2b2_b2b2, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb3b3_b3b3, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb4b4_b4b4, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb5b5_b5b5, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb6b6_b6b6, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb7b7_b7b7, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 32'hb8b8_b8b8, 1'b1, 1'b0, '0}
  };

  k_group_stream_reverser #(
    .MAX_GROUP(MAX_GRP),
    .DATA_WIDTH(DATA_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("k_group_stream_reverser test failed");
    $finish;
  end

  function automatic int active_group_size();
    if (grp_size_reg == 0) return 1;
    if (grp_size_reg > MAX_GRP) return MAX_GRP;
    return int'(grp_size_reg);
  endfunction

  // A full group leaves newest first; a list ending on a partial group keeps arrival order.
  function automatic void predict_reorder(input logic [DATA_W-1:0] v, input logic last);
    int k;
    int n;
    result_t r;
    k = active_group_size();
    reorder_out.delete();
    if (grp_fill < MAX_GRP) begin
      grp_store[grp_fill] = v;
      grp_fill++;
    end
    n = (grp_fill >= k || last) ? grp_fill : 0;
    for (int j = 0; j < n; j++) begin
      r.value = (grp_fill >= k) ? grp_store[grp_fill - 1 - j] : grp_store[j];
      r.run_last = (j == n - 1);
      r.list_done = last && (j == n - 1);
      reorder_out.push_back(r);
    end
    if (n > 0 || last) grp_fill = 0;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : transfer_monitor
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (awaited_values.size() == 0) begin
          flag_mismatch($sformatf("output transfer %h with nothing awaited", m_tdata));
        end else begin
          want = awaited_values.pop_front();
          values_checked++;
          if (m_tdata !== want.value)
            flag_mismatch($sformatf("out_value %h, wanted %h", m_tdata, want.value));
          if (m_tuser[0] !== want.run_last)
            flag_mismatch($sformatf("run_last %b, wanted %b on %h", m_tuser[0],
                                    want.run_last, want.value));
          if (m_tlast !== want.list_done)
            flag_mismatch($sformatf("list_done %b, wanted %b on %h", m_tlast,
                                    want.list_done, want.value));
        end
      end
      if (cfg_valid && cfg_ready) begin
        grp_size_reg = cfg_data;
        size_writes++;
      end
      if (s_tvalid && s_tready) begin
        predict_reorder(s_tdata, s_tlast);
        items_taken++;
        if (item_typed) begin
          awaited_values.push_back(item_want);
        end else begin
          foreach (reorder_out[i]) awaited_values.push_back(reorder_out[i]);
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 28);
  end

  task automatic send_item(input logic [DATA_W-1:0] v, input logic last,
                           input logic typed, input result_t want);
    if (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tlast <= last;
    item_typed <= typed;
    item_want <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_group_size(input logic [kgsr_pkg::CFG_W-1:0] k);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [kgsr_pkg::CFG_W-1:0] pick_group_size();
    case ($urandom_range(9))
      0: return kgsr_pkg::CFG_W'(0);
      1: return kgsr_pkg::CFG_W'(1);
      2: return kgsr_pkg::CFG_W'(16);
      3: return kgsr_pkg::CFG_W'(17);
      4: return kgsr_pkg::CFG_W'(31);
      default: return kgsr_pkg::CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  initial begin
    int sent;
    int phase;
    int phase_len;
    int list_len;
    int pos;
    logic open_end;
    logic last;
    sent = 0;
    phase = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_group_size(directed_rows[r].data[kgsr_pkg::CFG_W-1:0]);
      end else begin
        send_item(directed_rows[r].data, directed_rows[r].last, directed_rows[r].typed,
                  directed_rows[r].want);
      end
    end

    // Each phase drains fully, takes a new group size, then sends lists; some phases stop
    // mid-list so the next group size lands on a partly filled group.
    while (sent < RANDOM_ITEMS) begin
      steady = (phase == 3 || phase == 4);
      wait_idle();
      write_group_size(pick_group_size());
      phase_len = $urandom_range(20, 50);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      open_end = ($urandom_range(3) == 0);
      list_len = $urandom_range(1, 40);
      pos = 0;
      for (int n = 0; n < phase_len; n++) begin
        pos++;
        last = (pos >= list_len) || ($urandom_range(49) == 0);
        if (n == phase_len - 1) last = !open_end;
        send_item(pick_value(), last, 1'b0, '0);
        if (last) begin
          pos = 0;
          list_len = $urandom_range(1, 40);
        end
      end
      sent += phase_len;
      phase++;
    end
    steady = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d items over %0d group-size writes and %0d random phases.",
             items_taken, size_writes, phase);
    $display("Checked %0d reordered values; %0d mismatches.", values_checked, errors);
    if (errors == 0) begin
      $display("k_group_stream_reverser test passed");
    end else begin
      $display("k_group_stream_reverser test failed");
    end
    $finish;
  end

endmodule

@@ k_group_stream_reverser.f @@
design/kgsr_pkg.sv
design/kgsr_ctrl.sv
design/kgsr_datapath.sv
design/k_group_stream_reverser.sv
tb/sv/testbench.sv
